// File: rtl/clbp_pkg.sv
// Package for the circular LBP code block: request and register codes,
// field widths, default register values and the offset saturation helper.
// No dependencies.
package clbp_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_PIXEL = 2'd1;
	localparam logic [1:0] REQ_DRAIN = 2'd2;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_NBR_COUNT    = 2'd2;
	localparam logic [1:0] REG_RADIUS       = 2'd3;

	// Register field widths
	localparam int FW_W = 11;
	localparam int FH_W = 16;
	localparam int NC_W = 5;
	localparam int SR_W = 3;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Payload widths
	localparam int PIX_W  = 8;
	localparam int OFS_W  = 4;
	localparam int IDXF_W = 4;
	localparam int CODE_W = 16;

	// Register reset values
	localparam logic [FW_W-1:0] FW_RST = 11'd640;
	localparam logic [FH_W-1:0] FH_RST = 16'd480;
	localparam logic [NC_W-1:0] NC_RST = 5'd8;
	localparam logic [SR_W-1:0] SR_RST = 3'd1;

	// Default sizing
	localparam int DEF_MAX_NEIGHBOURS = 16;
	localparam int DEF_MAX_RADIUS     = 4;
	localparam int DEF_MAX_WIDTH      = 1024;

	// Clamp a loaded offset to [-r, +r]; the result fits only if r is at most 7
	function automatic logic signed [OFS_W-1:0] sat_offset(
		input logic signed [OFS_W-1:0] v,
		input logic [OFS_W-1:0] r
	);
		logic signed [OFS_W:0] vx;
		logic signed [OFS_W:0] rp;
		logic signed [OFS_W:0] rn;
		logic signed [OFS_W:0] res;
		vx = (OFS_W+1)'(v);
		rp = $signed({1'b0, r});
		rn = -rp;
		if (vx > rp) begin
			res = rp;
		end else if (vx < rn) begin
			res = rn;
		end else begin
			res = vx;
		end
		return res[OFS_W-1:0];
	endfunction

endpackage

// File: rtl/clbp_stream_if.sv
// Valid/ready channel interfaces for requests and code results.
// Depends on clbp_pkg.
interface clbp_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            req_type;
	logic [clbp_pkg::IDXF_W-1:0]           offset_index;
	logic signed [clbp_pkg::OFS_W-1:0]     row_offset;
	logic signed [clbp_pkg::OFS_W-1:0]     col_offset;
	logic [clbp_pkg::PIX_W-1:0]            pixel_value;

	modport source(output valid, req_type, offset_index, row_offset, col_offset,
		pixel_value, input ready);
	modport sink(input valid, req_type, offset_index, row_offset, col_offset,
		pixel_value, output ready);
endinterface

interface clbp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [clbp_pkg::CODE_W-1:0]   lbp_code;
	logic                          last_of_frame;

	modport source(output valid, lbp_code, last_of_frame, input ready);
	modport sink(input valid, lbp_code, last_of_frame, output ready);
endinterface

// File: rtl/clbp_line_mem.sv
// Single-write, single-read line store for recent pixels, registered read.
// Depends on clbp_pkg.
module clbp_line_mem #(
	parameter int DEPTH = 9225,
	parameter int AW    = 14
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [clbp_pkg::PIX_W-1:0]    wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [clbp_pkg::PIX_W-1:0]    rdata
);

	logic [clbp_pkg::PIX_W-1:0] mem [DEPTH];
	logic [clbp_pkg::PIX_W-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/clbp_core.sv
// Sequencer and shared compare unit: stores pixels, walks the neighbours of
// one centre per code, one line store read and one compare per cycle.
// Depends on clbp_pkg, clbp_stream_if.
module clbp_core #(
	parameter int MAX_NEIGHBOURS = clbp_pkg::DEF_MAX_NEIGHBOURS,
	parameter int MAX_RADIUS     = clbp_pkg::DEF_MAX_RADIUS,
	parameter int MAX_WIDTH      = clbp_pkg::DEF_MAX_WIDTH,
	parameter int WID_W          = $clog2(MAX_WIDTH + 1),
	parameter int RAD_W          = $clog2(MAX_RADIUS + 1),
	parameter int NB_W           = $clog2(MAX_NEIGHBOURS + 1),
	parameter int DEPTH          = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1),
	parameter int AW             = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	clbp_req_if.sink                      req,
	clbp_rsp_if.source                    rsp,
	input  logic [WID_W-1:0]              eff_width,
	input  logic [clbp_pkg::FH_W-1:0]     eff_height,
	input  logic [RAD_W-1:0]              eff_radius,
	input  logic [NB_W-1:0]               eff_nbrs,
	input  logic                          width_wr,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [clbp_pkg::PIX_W-1:0]    mem_wdata,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [clbp_pkg::PIX_W-1:0]    mem_rdata
);

	localparam int CNT_W  = WID_W + clbp_pkg::FH_W;
	localparam int IDX_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int DCNT_W = $clog2(CNT_W + 1);
	localparam int SUM_W  = AW + 2;
	localparam int NI_W   = CNT_W + 2;
	localparam int NJ_W   = WID_W + 2;
	localparam int OW     = clbp_pkg::OFS_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_CEN  = 3'd2;
	localparam logic [2:0] S_NB   = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]                     state_q;
	logic [CNT_W-1:0]               pr_q;
	logic [CNT_W-1:0]               ce_q;
	logic [AW-1:0]                  wr_addr_q;
	logic [AW-1:0]                  cen_addr_q;
	logic [CNT_W-1:0]               row_q;
	logic [WID_W-1:0]               col_q;
	logic                           dirty_q;
	logic [WID_W-1:0]               rem_q;
	logic [DCNT_W-1:0]              div_cnt_q;
	logic [OW-1:0]                  rtab_q [MAX_NEIGHBOURS];
	logic [OW-1:0]                  ctab_q [MAX_NEIGHBOURS];
	logic [NB_W-1:0]                p_q;
	logic                           pend_s1;
	logic                           inb_s1;
	logic [NB_W-1:0]                bit_s1;
	logic                           cen_ld_q;
	logic [clbp_pkg::PIX_W-1:0]     centre_q;
	logic [clbp_pkg::CODE_W-1:0]    code_q;
	logic                           ovalid_q;
	logic [clbp_pkg::CODE_W-1:0]    ocode_q;
	logic                           olast_q;

	logic [CNT_W-1:0]               total;
	logic [CNT_W-1:0]               delay;
	logic                           acc;
	logic [CNT_W-1:0]               pr_inc;
	logic [CNT_W-1:0]               ce_inc;
	logic                           pix_ok;
	logic                           pix_emit;
	logic [AW-1:0]                  wr_addr_inc;
	logic [AW-1:0]                  cen_addr_inc;
	logic [WID_W:0]                 trial;
	logic                           qbit;
	logic [WID_W-1:0]               rem_n;
	logic [IDX_W-1:0]               nidx;
	logic signed [OW-1:0]           dr;
	logic signed [OW-1:0]           dc;
	logic signed [NI_W-1:0]         ni;
	logic signed [NJ_W-1:0]         nj;
	logic                           inb;
	logic signed [SUM_W-1:0]        off_sum;
	logic [AW-1:0]                  nb_addr;
	logic                           out_free;
	logic [WID_W:0]                 col_inc;

	// Frame size and code delay from the effective registers
	assign total = CNT_W'(eff_width) * CNT_W'(eff_height);
	assign delay = CNT_W'(eff_radius) * CNT_W'(eff_width) + CNT_W'(eff_radius);

	assign acc      = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign pr_inc   = pr_q + CNT_W'(1);
	assign ce_inc   = ce_q + CNT_W'(1);
	assign pix_ok   = (pr_q < total);
	assign pix_emit = (pr_inc > ce_q) && ((pr_inc - ce_q) > delay);

	// Ring addresses wrap at the line store depth
	assign wr_addr_inc  = (32'(wr_addr_q) == DEPTH - 1) ? '0 : wr_addr_q + AW'(1);
	assign cen_addr_inc = (32'(cen_addr_q) == DEPTH - 1) ? '0 : cen_addr_q + AW'(1);

	// One restoring division step: raster index over width
	assign trial = {rem_q, row_q[CNT_W-1]};
	assign qbit  = (trial >= (WID_W+1)'(eff_width));
	assign rem_n = qbit ? WID_W'(trial - (WID_W+1)'(eff_width)) : WID_W'(trial);

	// Neighbour position, frame test and ring address
	assign nidx = IDX_W'(p_q);
	assign dr   = clbp_pkg::sat_offset($signed(rtab_q[nidx]), OW'(eff_radius));
	assign dc   = clbp_pkg::sat_offset($signed(ctab_q[nidx]), OW'(eff_radius));
	assign ni   = $signed(NI_W'(row_q)) + NI_W'(dr);
	assign nj   = $signed(NJ_W'(col_q)) + NJ_W'(dc);
	assign inb  = (ni >= 0) && (ni < $signed(NI_W'(eff_height))) &&
		(nj >= 0) && (nj < $signed(NJ_W'(eff_width)));
	assign off_sum = $signed(SUM_W'(cen_addr_q)) +
		SUM_W'(dr) * $signed(SUM_W'(eff_width)) + SUM_W'(dc);

	always_comb begin
		if (off_sum < 0) begin
			nb_addr = AW'(off_sum + SUM_W'(DEPTH));
		end else if (off_sum >= $signed(SUM_W'(DEPTH))) begin
			nb_addr = AW'(off_sum - SUM_W'(DEPTH));
		end else begin
			nb_addr = AW'(off_sum);
		end
	end

	// Line store ports
	assign mem_we    = acc && (req.req_type == clbp_pkg::REQ_PIXEL) && pix_ok;
	assign mem_waddr = wr_addr_q;
	assign mem_wdata = req.pixel_value;
	assign mem_raddr = (state_q == S_CEN) ? cen_addr_q : nb_addr;

	assign out_free = !ovalid_q || rsp.ready;
	assign col_inc  = (WID_W+1)'(col_q) + (WID_W+1)'(1);

	// Offset tables
	always_ff @(posedge clk) begin
		if (acc && (req.req_type == clbp_pkg::REQ_LOAD) &&
			(32'(req.offset_index) < MAX_NEIGHBOURS)) begin
			rtab_q[IDX_W'(req.offset_index)] <= req.row_offset;
			ctab_q[IDX_W'(req.offset_index)] <= req.col_offset;
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == S_DIV) begin
			rem_q <= rem_n;
		end else begin
			rem_q <= '0;
		end
		if (cen_ld_q) begin
			centre_q <= mem_rdata;
		end
		if (state_q == S_NB) begin
			inb_s1 <= inb;
			bit_s1 <= p_q;
		end
		if ((state_q == S_OUT) && out_free) begin
			ocode_q <= code_q;
			olast_q <= (ce_inc >= total);
		end
	end

	// Width change marks the row and column tracking stale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
		end else if (width_wr) begin
			dirty_q <= 1'b1;
		end else if (((state_q == S_DIV) && (div_cnt_q == DCNT_W'(1))) ||
			((state_q == S_OUT) && out_free && (ce_inc >= total))) begin
			dirty_q <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pr_q       <= '0;
			ce_q       <= '0;
			wr_addr_q  <= '0;
			cen_addr_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			div_cnt_q  <= '0;
			p_q        <= '0;
			pend_s1    <= 1'b0;
			cen_ld_q   <= 1'b0;
			code_q     <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						code_q <= '0;
						if (dirty_q) begin
							row_q     <= ce_q;
							div_cnt_q <= DCNT_W'(CNT_W);
						end
						case (req.req_type)
							clbp_pkg::REQ_PIXEL: begin
								if (pix_ok) begin
									pr_q      <= pr_inc;
									wr_addr_q <= wr_addr_inc;
									if (pix_emit) begin
										state_q <= dirty_q ? S_DIV : S_CEN;
									end
								end
							end
							clbp_pkg::REQ_DRAIN: begin
								if (ce_q < pr_q) begin
									state_q <= dirty_q ? S_DIV : S_CEN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV: begin
					row_q     <= {row_q[CNT_W-2:0], qbit};
					div_cnt_q <= div_cnt_q - DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(1)) begin
						col_q   <= rem_n;
						state_q <= S_CEN;
					end
				end
				S_CEN: begin
					cen_ld_q <= 1'b1;
					p_q      <= '0;
					pend_s1  <= 1'b0;
					state_q  <= S_NB;
				end
				S_NB: begin
					cen_ld_q <= 1'b0;
					if (pend_s1 && inb_s1 && (mem_rdata >= centre_q) &&
						(32'(bit_s1) < clbp_pkg::CODE_W)) begin
						code_q[bit_s1[$clog2(clbp_pkg::CODE_W)-1:0]] <= 1'b1;
					end
					if (p_q < eff_nbrs) begin
						pend_s1 <= 1'b1;
						p_q     <= p_q + NB_W'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q  <= S_IDLE;
						if (ce_inc >= total) begin
							ce_q       <= '0;
							pr_q       <= '0;
							cen_addr_q <= '0;
							wr_addr_q  <= '0;
							row_q      <= '0;
							col_q      <= '0;
						end else begin
							ce_q       <= ce_inc;
							cen_addr_q <= cen_addr_inc;
							if (col_inc >= (WID_W+1)'(eff_width)) begin
								col_q <= '0;
								row_q <= row_q + CNT_W'(1);
							end else begin
								col_q <= WID_W'(col_inc);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = ovalid_q;
	assign rsp.lbp_code      = ocode_q;
	assign rsp.last_of_frame = olast_q;

endmodule

// File: rtl/circular_lbp_code_top.sv
// Top level of the circular LBP code block: APB registers, sequencer core
// and line store. Depends on clbp_pkg, clbp_stream_if, clbp_core, clbp_line_mem.

// Offset loads, pixels that produce no code and ignored requests leave the
// sequencer idle. A pixel or drain that produces a code goes through these
// steps: the accepting cycle, a state that reads the centre, one line store
// read and one compare per neighbour through the single read port, then the
// steps that finish the last compare and close the walk, then a state that
// hands the result to the output register, waiting while it holds an untaken
// code. The first code after a frame_width write first passes through the
// bit-serial unit that recomputes the centre's row and column. The output
// register lets the next request enter while a code waits to be taken. No
// clearing pass is needed after reset.
module circular_lbp_code_top #(
	parameter int MAX_NEIGHBOURS = clbp_pkg::DEF_MAX_NEIGHBOURS,
	parameter int MAX_RADIUS     = clbp_pkg::DEF_MAX_RADIUS,
	parameter int MAX_WIDTH      = clbp_pkg::DEF_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	clbp_req_if.sink                          req,
	clbp_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [clbp_pkg::PADDR_W-1:0]      paddr,
	input  logic [clbp_pkg::PDATA_W-1:0]      pwdata,
	output logic [clbp_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);

	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int RAD_W = $clog2(MAX_RADIUS + 1);
	localparam int NB_W  = $clog2(MAX_NEIGHBOURS + 1);
	localparam int DEPTH = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);
	localparam int AW    = $clog2(DEPTH);

	logic [clbp_pkg::FW_W-1:0] fw_q;
	logic [clbp_pkg::FH_W-1:0] fh_q;
	logic [clbp_pkg::NC_W-1:0] nc_q;
	logic [clbp_pkg::SR_W-1:0] sr_q;
	logic                      wr_en;
	logic [1:0]                reg_idx;
	logic [WID_W-1:0]          eff_width;
	logic [clbp_pkg::FH_W-1:0] eff_height;
	logic [RAD_W-1:0]          eff_radius;
	logic [NB_W-1:0]           eff_nbrs;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [clbp_pkg::PIX_W-1:0] mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic [clbp_pkg::PIX_W-1:0] mem_rdata;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= clbp_pkg::FW_RST;
			fh_q <= clbp_pkg::FH_RST;
			nc_q <= clbp_pkg::NC_RST;
			sr_q <= clbp_pkg::SR_RST;
		end else if (wr_en) begin
			case (reg_idx)
				clbp_pkg::REG_FRAME_WIDTH:  fw_q <= pwdata[clbp_pkg::FW_W-1:0];
				clbp_pkg::REG_FRAME_HEIGHT: fh_q <= pwdata[clbp_pkg::FH_W-1:0];
				clbp_pkg::REG_NBR_COUNT:    nc_q <= pwdata[clbp_pkg::NC_W-1:0];
				clbp_pkg::REG_RADIUS:       sr_q <= pwdata[clbp_pkg::SR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (reg_idx)
			clbp_pkg::REG_FRAME_WIDTH:  prdata = clbp_pkg::PDATA_W'(fw_q);
			clbp_pkg::REG_FRAME_HEIGHT: prdata = clbp_pkg::PDATA_W'(fh_q);
			clbp_pkg::REG_NBR_COUNT:    prdata = clbp_pkg::PDATA_W'(nc_q);
			clbp_pkg::REG_RADIUS:       prdata = clbp_pkg::PDATA_W'(sr_q);
			default:                    prdata = '0;
		endcase
	end

	// Clamp registers into their working ranges
	always_comb begin
		if (fw_q == '0) begin
			eff_width = WID_W'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			eff_width = WID_W'(MAX_WIDTH);
		end else begin
			eff_width = WID_W'(fw_q);
		end
		eff_height = (fh_q == '0) ? clbp_pkg::FH_W'(1) : fh_q;
		if (sr_q == '0) begin
			eff_radius = RAD_W'(1);
		end else if (32'(sr_q) > MAX_RADIUS) begin
			eff_radius = RAD_W'(MAX_RADIUS);
		end else begin
			eff_radius = RAD_W'(sr_q);
		end
		if (32'(nc_q) > MAX_NEIGHBOURS) begin
			eff_nbrs = NB_W'(MAX_NEIGHBOURS);
		end else begin
			eff_nbrs = NB_W'(nc_q);
		end
	end

	clbp_core #(
		.MAX_NEIGHBOURS(MAX_NEIGHBOURS),
		.MAX_RADIUS    (MAX_RADIUS),
		.MAX_WIDTH     (MAX_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.eff_width (eff_width),
		.eff_height(eff_height),
		.eff_radius(eff_radius),
		.eff_nbrs  (eff_nbrs),
		.width_wr  (wr_en && (reg_idx == clbp_pkg::REG_FRAME_WIDTH)),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	clbp_line_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_line_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// File: rtl/clbp_checker.sv
// Port-level checks for the circular LBP code block, bound to the top level.
// Depends on clbp_pkg and circular_lbp_code_top.
module clbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [1:0]                    req_type,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [clbp_pkg::CODE_W-1:0]   lbp_code,
	input logic                          last_of_frame
);

	// A waiting result holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(lbp_code) &&
		$stable(last_of_frame))
		else $error("result changed while stalled");

	// A fresh result only follows a busy cycle of the sequencer
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without a compute pass");

	// Offset loads never stall the request side
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == clbp_pkg::REQ_LOAD) |=> req_ready)
		else $error("offset load left the block busy");

	// A pixel never yields a result in the very next cycle
	a_pixel_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == clbp_pkg::REQ_PIXEL) |=>
		!$rose(rsp_valid))
		else $error("result too early after pixel");

endmodule

bind circular_lbp_code_top clbp_checker u_clbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_type     (req.req_type),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.lbp_code     (rsp.lbp_code),
	.last_of_frame(rsp.last_of_frame)
);

// File: test/tb.sv
// Self-checking testbench for circular_lbp_code_top: random bursts of offset loads, pixels and
// drains checked against an in-bench predictor of the LBP codes, with APB register phases.
// Depends on clbp_pkg, clbp_stream_if and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH =
		(2 * clbp_pkg::DEF_MAX_RADIUS + 1) * (clbp_pkg::DEF_MAX_WIDTH + 1);
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 100;
	// Request code the block does not know
	localparam logic [1:0] REQ_BAD = 2'd3;

	typedef struct packed {
		logic [1:0]                        kind;
		logic [clbp_pkg::IDXF_W-1:0]       idx;
		logic signed [clbp_pkg::OFS_W-1:0] ro;
		logic signed [clbp_pkg::OFS_W-1:0] co;
		logic [clbp_pkg::PIX_W-1:0]        pix;
	} lbp_req_t;

	typedef struct packed {
		logic [clbp_pkg::CODE_W-1:0] code;
		logic                        last;
	} lbp_code_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [clbp_pkg::PADDR_W-1:0] paddr;
	logic [clbp_pkg::PDATA_W-1:0] pwdata;
	logic [clbp_pkg::PDATA_W-1:0] prdata;
	logic pready;

	clbp_req_if req_ch();
	clbp_rsp_if rsp_ch();

	circular_lbp_code_top dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Shadow of block state for prediction
	logic [clbp_pkg::FW_W-1:0] sh_width;
	logic [clbp_pkg::FH_W-1:0] sh_height;
	logic [clbp_pkg::NC_W-1:0] sh_nbrs;
	logic [clbp_pkg::SR_W-1:0] sh_radius;
	logic [clbp_pkg::PIX_W-1:0] sh_lines [LINE_DEPTH];
	logic signed [clbp_pkg::OFS_W-1:0] sh_rofs [16];
	logic signed [clbp_pkg::OFS_W-1:0] sh_cofs [16];
	int unsigned pix_rx;
	int unsigned codes_out;

	lbp_req_t  pending_reqs[$];
	lbp_code_t expected_codes[$];
	int err_cnt = 0;
	int items_made = 0;
	int codes_seen = 0;

	function automatic int unsigned eff_w();
		if (sh_width == 0) return 1;
		return (sh_width > clbp_pkg::DEF_MAX_WIDTH) ? clbp_pkg::DEF_MAX_WIDTH : sh_width;
	endfunction

	function automatic int unsigned eff_h();
		return (sh_height == 0) ? 1 : sh_height;
	endfunction

	function automatic int eff_r();
		if (sh_radius == 0) return 1;
		return (sh_radius > clbp_pkg::DEF_MAX_RADIUS) ? clbp_pkg::DEF_MAX_RADIUS :
			int'(sh_radius);
	endfunction

	function automatic int clamp_ofs(int v, int r);
		if (v > r) return r;
		if (v < -r) return -r;
		return v;
	endfunction

	// Code of pixel k from the shadow line store, then advance the output count
	function automatic void emit_code();
		int unsigned w, k, np, p;
		int h, r, i, j, ni, nj;
		logic [clbp_pkg::PIX_W-1:0] centre;
		lbp_code_t res;
		w = eff_w();
		h = int'(eff_h());
		r = eff_r();
		np = (sh_nbrs > clbp_pkg::DEF_MAX_NEIGHBOURS) ? clbp_pkg::DEF_MAX_NEIGHBOURS : sh_nbrs;
		k = codes_out;
		i = int'(k / w);
		j = int'(k % w);
		centre = sh_lines[k % LINE_DEPTH];
		res = '0;
		for (p = 0; p < np; p++) begin
			ni = i + clamp_ofs(int'(sh_rofs[p]), r);
			nj = j + clamp_ofs(int'(sh_cofs[p]), r);
			if (ni >= 0 && ni < h && nj >= 0 && nj < int'(w)) begin
				if (sh_lines[(ni * w + nj) % LINE_DEPTH] >= centre) res.code[p] = 1'b1;
			end
		end
		codes_out++;
		if (codes_out >= w * eff_h()) begin
			res.last = 1'b1;
			codes_out = 0;
			pix_rx = 0;
		end
		expected_codes.push_back(res);
	endfunction

	// Predict the effect of one request and queue it for the driver
	function automatic void lbp_push(lbp_req_t t);
		int unsigned w, total, delay;
		items_made++;
		pending_reqs.push_back(t);
		case (t.kind)
			clbp_pkg::REQ_LOAD: begin
				sh_rofs[t.idx] = t.ro;
				sh_cofs[t.idx] = t.co;
			end
			clbp_pkg::REQ_PIXEL: begin
				w = eff_w();
				total = w * eff_h();
				delay = eff_r() * w + eff_r();
				if (pix_rx < total) begin
					sh_lines[pix_rx % LINE_DEPTH] = t.pix;
					pix_rx++;
					if (pix_rx > codes_out && pix_rx - codes_out > delay) emit_code();
				end
			end
			clbp_pkg::REQ_DRAIN: begin
				if (codes_out < pix_rx) emit_code();
			end
			default: ;
		endcase
	endfunction

	function automatic void send_pix(logic [clbp_pkg::PIX_W-1:0] v);
		lbp_req_t t;
		t = lbp_req_t'($urandom);
		t.kind = clbp_pkg::REQ_PIXEL;
		t.pix = v;
		lbp_push(t);
	endfunction

	function automatic void send_load(int p, int ro, int co);
		lbp_req_t t;
		t = lbp_req_t'($urandom);
		t.kind = clbp_pkg::REQ_LOAD;
		t.idx = p[clbp_pkg::IDXF_W-1:0];
		t.ro = ro[clbp_pkg::OFS_W-1:0];
		t.co = co[clbp_pkg::OFS_W-1:0];
		lbp_push(t);
	endfunction

	function automatic void send_ctl(logic [1:0] kind);
		lbp_req_t t;
		t = lbp_req_t'($urandom);
		t.kind = kind;
		lbp_push(t);
	endfunction

	// Random offset: mostly within the radius, sometimes the whole 4-bit range
	function automatic int rand_ofs();
		int r;
		r = eff_r();
		if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 15)) - 8;
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic void load_all_offsets();
		for (int p = 0; p < 16; p++) send_load(p, rand_ofs(), rand_ofs());
	endfunction

	function automatic logic [clbp_pkg::PIX_W-1:0] rand_pix();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd128 + clbp_pkg::PIX_W'($urandom_range(0, 3));
			default: return clbp_pkg::PIX_W'($urandom);
		endcase
	endfunction

	// Random frames: pixels with noise, drains mid-frame only when no code is owed
	function automatic void run_frames(int nframes);
		int unsigned total;
		for (int f = 0; f < nframes; f++) begin
			total = eff_w() * eff_h();
			while (pix_rx < total) begin
				case ($urandom_range(0, 99)) inside
					[0:3]:   send_load($urandom_range(0, 15), rand_ofs(), rand_ofs());
					[4:6]:   send_ctl(REQ_BAD);
					[7:8]:   if (pix_rx == codes_out) send_ctl(clbp_pkg::REQ_DRAIN);
					default: send_pix(rand_pix());
				endcase
			end
			for (int e = $urandom_range(0, 2); e > 0; e--) send_pix(rand_pix());
			while (pix_rx != 0) send_ctl(clbp_pkg::REQ_DRAIN);
			if ($urandom_range(0, 2) == 0) send_ctl(clbp_pkg::REQ_DRAIN);
		end
	endfunction

	// Wait until every request is taken and every code has arrived, then settle
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_codes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] regi, logic [clbp_pkg::PDATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= clbp_pkg::PADDR_W'(regi) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(int w, int h, int nc, int r);
		wait_idle();
		apb_write(clbp_pkg::REG_FRAME_WIDTH, w);
		apb_write(clbp_pkg::REG_FRAME_HEIGHT, h);
		apb_write(clbp_pkg::REG_NBR_COUNT, nc);
		apb_write(clbp_pkg::REG_RADIUS, r);
		sh_width = w[clbp_pkg::FW_W-1:0];
		sh_height = h[clbp_pkg::FH_W-1:0];
		sh_nbrs = nc[clbp_pkg::NC_W-1:0];
		sh_radius = r[clbp_pkg::SR_W-1:0];
	endtask

	// Driver: bursts of random length with random gaps, valid held until taken
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		logic fire;
		logic nv;
		if (arst_n) begin
			fire = req_ch.valid && req_ch.ready;
			if (fire) pending_reqs.pop_front();
			if (!req_ch.valid || fire) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					nv = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				req_ch.valid <= nv;
				if (nv) begin
					req_ch.req_type <= pending_reqs[0].kind;
					req_ch.offset_index <= pending_reqs[0].idx;
					req_ch.row_offset <= pending_reqs[0].ro;
					req_ch.col_offset <= pending_reqs[0].co;
					req_ch.pixel_value <= pending_reqs[0].pix;
				end
			end
		end
	end

	// Receiver: alternating stretches of full rate and random stalls, one long hold-off
	int hold_left = 0;
	bit long_done = 0;
	int rx_phase = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			rx_phase++;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!long_done && codes_seen >= 150) begin
				long_done = 1;
				hold_left = 400;
				rsp_ch.ready <= 1'b0;
			end else if ((rx_phase / 64) % 2 == 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 9) < 6);
			end
		end
	end

	// Monitor: check each code transaction against the oldest expectation
	always @(posedge clk) begin
		lbp_code_t exp_c;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			codes_seen++;
			if (expected_codes.size() == 0) begin
				$error("unexpected code transaction: lbp_code %h", rsp_ch.lbp_code);
				err_cnt++;
			end else begin
				exp_c = expected_codes.pop_front();
				if (rsp_ch.lbp_code !== exp_c.code) begin
					$error("lbp_code expected %h actual %h", exp_c.code, rsp_ch.lbp_code);
					err_cnt++;
				end
				if (rsp_ch.last_of_frame !== exp_c.last) begin
					$error("last_of_frame expected %b actual %b", exp_c.last,
						rsp_ch.last_of_frame);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction while work is outstanding
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(pending_reqs.size() == 0 && expected_codes.size() == 0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		int rows [8];
		int cols [8];
		rows = '{0, -1, -1, -1, 0, 1, 1, 1};
		cols = '{1, 1, 0, -1, -1, -1, 0, 1};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = clbp_pkg::REQ_LOAD;
		req_ch.offset_index = '0;
		req_ch.row_offset = '0;
		req_ch.col_offset = '0;
		req_ch.pixel_value = '0;
		rsp_ch.ready = 1'b0;
		sh_width = clbp_pkg::FW_RST;
		sh_height = clbp_pkg::FH_RST;
		sh_nbrs = clbp_pkg::NC_RST;
		sh_radius = clbp_pkg::SR_RST;
		pix_rx = 0;
		codes_out = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: classic 8-point radius-1 circle on a 4x3 frame
		set_config(4, 3, 8, 1);
		for (int p = 0; p < 8; p++) send_load(p, rows[p], cols[p]);
		for (int p = 8; p < 16; p++) send_load(p, 7, -8);
		send_ctl(clbp_pkg::REQ_DRAIN);
		send_ctl(REQ_BAD);
		send_pix(8'd0);
		send_pix(8'd255);
		send_pix(8'd128);
		send_pix(8'd128);
		for (int n = 0; n < 8; n++) send_pix(8'd85 << (n % 2));
		send_pix(8'd7);
		send_ctl(clbp_pkg::REQ_DRAIN);
		send_ctl(clbp_pkg::REQ_DRAIN);
		send_ctl(clbp_pkg::REQ_DRAIN);
		send_ctl(clbp_pkg::REQ_DRAIN);
		send_ctl(clbp_pkg::REQ_DRAIN);

		// Tallest frame: partial frame, then height cut down and drained
		set_config(1, 65535, 16, 1);
		load_all_offsets();
		for (int n = 0; n < 20; n++) send_pix(rand_pix());
		set_config(1, 20, 16, 1);
		while (pix_rx != 0) send_ctl(clbp_pkg::REQ_DRAIN);

		// Widest row, radius and count above range
		set_config(2047, 1, 31, 7);
		load_all_offsets();
		run_frames(1);

		// All registers zero
		set_config(0, 0, 0, 0);
		run_frames(3);

		set_config(5, 4, 16, 4);
		load_all_offsets();
		run_frames(2);

		// Random phases
		while (items_made < 1750) begin
			set_config($urandom_range(1, 12), $urandom_range(1, 10),
				$urandom_range(1, 16), $urandom_range(1, 4));
			load_all_offsets();
			run_frames($urandom_range(1, 3));
		end

		wait_idle();
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
